@@ rtl/hex_binary_text_to_bytes_top_macros.svh @@
// assertion macros shared by the text-to-bytes converter modules
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef HEX_BINARY_TEXT_TO_BYTES_TOP_MACROS_SVH
`define HEX_BINARY_TEXT_TO_BYTES_TOP_MACROS_SVH

// condition holds at every clock edge outside reset
`define HBT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define HBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hbt_pkg.sv @@
// types and constants for the text-to-bytes converter
// no dependencies; imported by every module of the block
package hbt_pkg;

  typedef enum logic [1:0] {
    MODE_HEX  = 2'd0,
    MODE_BIN  = 2'd1,
    MODE_TEXT = 2'd2
  } mode_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_DQUOTE = 8'h22;
  localparam logic [7:0] CHR_HASH   = 8'h23;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_SQUOTE = 8'h27;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_1      = 8'h31;
  localparam logic [7:0] CHR_9      = 8'h39;
  localparam logic [7:0] CHR_UA     = 8'h41;
  localparam logic [7:0] CHR_UF     = 8'h46;
  localparam logic [7:0] CHR_LA     = 8'h61;
  localparam logic [7:0] CHR_LF     = 8'h66;

  // offsets that map a letter digit onto 10..15
  localparam logic [7:0] OFS_UPPER = 8'h37;
  localparam logic [7:0] OFS_LOWER = 8'h57;

  localparam logic [3:0] BITS_BYTE = 4'd8;
  localparam logic [3:0] BITS_HEX  = 4'd4;
  localparam logic [3:0] BITS_BIN  = 4'd1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam int TDATA_W = 32;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        failed;
    logic [15:0] count;
    logic        last;
  } res_t;

  // up to two results per character, a before b
  typedef struct packed {
    logic va;
    res_t res_a;
    logic vb;
    res_t res_b;
  } push_t;

endpackage

@@ rtl/hbt_conv.sv @@
// character input register, conversion state and per-character step logic
// depends on hbt_pkg and the assertion macro header
`include "hex_binary_text_to_bytes_top_macros.svh"

module hbt_conv import hbt_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // char_code
  input  logic [15:0] output_limit,
  input  logic        room2,
  output push_t       push
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0] CLIP_MAX = CMP_W'(17'h0FFFF);

  logic                   in_valid;
  logic [7:0]             in_char;
  mode_t                  active_mode, active_mode_next;
  mode_t                  pending_mode, pending_mode_next;
  logic [7:0]             partial_value, partial_value_next;
  logic [3:0]             bits_collected, bits_collected_next;
  logic [7:0]             quote_char, quote_char_next;
  logic [COUNT_WIDTH-1:0] produced_count;
  logic                   error_seen, error_seen_next;

  logic                   fire;
  logic                   hex_ok, bin_ok;
  logic [3:0]             hex_digit;
  logic                   prod_a, prod_b, term;
  logic [7:0]             byte_b;
  logic [7:0]             pv1, pv2;
  logic [3:0]             bc1, bc2;
  logic [COUNT_WIDTH-1:0] cnt1, cnt2;
  logic [CMP_W-1:0]       lim_ext, cnt0_ext, cnt1_ext;
  logic                   emit_a, emit_b;
  logic [15:0]            status_count;

  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  // digit decode
  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (in_char >= CHR_0 && in_char <= CHR_9) begin
      hex_digit = 4'(in_char - CHR_0);
    end else if (in_char >= CHR_LA && in_char <= CHR_LF) begin
      hex_digit = 4'(in_char - OFS_LOWER);
    end else if (in_char >= CHR_UA && in_char <= CHR_UF) begin
      hex_digit = 4'(in_char - OFS_UPPER);
    end else begin
      hex_ok = 1'b0;
    end
    bin_ok = (in_char == CHR_0) || (in_char == CHR_1);
  end

  // one character step
  always_comb begin
    active_mode_next    = active_mode;
    pending_mode_next   = pending_mode;
    partial_value_next  = partial_value;
    bits_collected_next = bits_collected;
    quote_char_next     = quote_char;
    error_seen_next     = error_seen;
    prod_a = 1'b0;
    prod_b = 1'b0;
    term   = 1'b0;
    byte_b = in_char;
    pv1    = partial_value;
    bc1    = bits_collected;
    pv2    = 8'd0;
    bc2    = 4'd0;
    if (fire) begin
      if (in_char == CHR_NUL) begin
        term   = 1'b1;
        prod_a = !error_seen && (bits_collected != 4'd0);
        active_mode_next    = MODE_HEX;
        pending_mode_next   = MODE_HEX;
        partial_value_next  = 8'd0;
        bits_collected_next = 4'd0;
        quote_char_next     = 8'd0;
        error_seen_next     = 1'b0;
      end else if (!error_seen) begin
        // pending mode change flushes the partial value first
        if (active_mode != pending_mode) begin
          active_mode_next = pending_mode;
          prod_a = (bits_collected != 4'd0);
          pv1    = 8'd0;
          bc1    = 4'd0;
        end
        partial_value_next  = pv1;
        bits_collected_next = bc1;
        if (pending_mode == MODE_TEXT) begin
          if (in_char != quote_char) begin
            prod_b = 1'b1;
          end else begin
            pending_mode_next = MODE_HEX;
          end
        end else if (in_char == CHR_SPACE) begin
          prod_b = (bc1 != 4'd0);
          byte_b = pv1;
          partial_value_next  = 8'd0;
          bits_collected_next = 4'd0;
        end else if (in_char == CHR_SQUOTE || in_char == CHR_DQUOTE) begin
          pending_mode_next = MODE_TEXT;
          quote_char_next   = in_char;
        end else if (in_char == CHR_DOLLAR) begin
          pending_mode_next = MODE_HEX;
        end else if (in_char == CHR_HASH) begin
          pending_mode_next = MODE_BIN;
        end else begin
          unique case (pending_mode)
            MODE_HEX: begin
              pv2 = {pv1[3:0], hex_digit};
              bc2 = bc1 + BITS_HEX;
              if (!hex_ok) error_seen_next = 1'b1;
            end
            MODE_BIN: begin
              pv2 = {pv1[6:0], in_char[0]};
              bc2 = bc1 + BITS_BIN;
              if (!bin_ok) error_seen_next = 1'b1;
            end
            default: begin
              error_seen_next = 1'b1;
            end
          endcase
          if (!error_seen_next) begin
            if (bc2 >= BITS_BYTE) begin
              prod_b = 1'b1;
              byte_b = pv2;
              partial_value_next  = 8'd0;
              bits_collected_next = 4'd0;
            end else begin
              partial_value_next  = pv2;
              bits_collected_next = bc2;
            end
          end
        end
      end
    end
  end

  // byte counting against the limit, flushed byte counted first
  always_comb begin
    lim_ext  = CMP_W'(output_limit);
    cnt0_ext = CMP_W'(produced_count);
    emit_a   = prod_a && (cnt0_ext < lim_ext);
    cnt1     = (prod_a && produced_count != CNT_MAX) ? produced_count + 1'b1 : produced_count;
    cnt1_ext = CMP_W'(cnt1);
    emit_b   = prod_b && (cnt1_ext < lim_ext);
    cnt2     = (prod_b && cnt1 != CNT_MAX) ? cnt1 + 1'b1 : cnt1;
    if (error_seen) begin
      status_count = 16'd0;
    end else if (cnt1_ext > CLIP_MAX) begin
      status_count = 16'hFFFF;
    end else begin
      status_count = cnt1_ext[15:0];
    end
  end

  always_comb begin
    push.va           = emit_a;
    push.res_a.kind   = KIND_DATA;
    push.res_a.data   = partial_value;
    push.res_a.failed = 1'b0;
    push.res_a.count  = 16'd0;
    push.res_a.last   = 1'b0;
    push.vb           = term || emit_b;
    if (term) begin
      push.res_b.kind   = KIND_STATUS;
      push.res_b.data   = 8'd0;
      push.res_b.failed = error_seen;
      push.res_b.count  = status_count;
      push.res_b.last   = 1'b1;
    end else begin
      push.res_b.kind   = KIND_DATA;
      push.res_b.data   = byte_b;
      push.res_b.failed = 1'b0;
      push.res_b.count  = 16'd0;
      push.res_b.last   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode    <= MODE_HEX;
      pending_mode   <= MODE_HEX;
      partial_value  <= 8'd0;
      bits_collected <= 4'd0;
      quote_char     <= 8'd0;
      produced_count <= '0;
      error_seen     <= 1'b0;
    end else begin
      active_mode    <= active_mode_next;
      pending_mode   <= pending_mode_next;
      partial_value  <= partial_value_next;
      bits_collected <= bits_collected_next;
      quote_char     <= quote_char_next;
      produced_count <= term ? '0 : cnt2;
      error_seen     <= error_seen_next;
    end
  end

  `HBT_ASSERT_ALWAYS(a_bits_below_byte, bits_collected < BITS_BYTE, "partial value holds a full byte")
  `HBT_ASSERT_NEXT(a_term_clears, fire && in_char == CHR_NUL, produced_count == '0 && !error_seen && bits_collected == 4'd0, "state not cleared after terminator")
  `HBT_ASSERT_IMP(a_error_silent, fire && error_seen && in_char != CHR_NUL, !push.va && !push.vb, "result after invalid digit")

endmodule

@@ rtl/hbt_outq.sv @@
// four-entry result queue, two writes and one read per cycle
// depends on hbt_pkg and the assertion macro header
`include "hex_binary_text_to_bytes_top_macros.svh"

module hbt_outq import hbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  output logic               room2,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // data_byte, failed, byte_count, zero fill
  output logic               m_tuser,   // kind
  output logic               m_tlast    // is_last
);

  res_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_CNT_W-1:0] count;
  logic               pop;
  logic               any_push;
  res_t               first;
  logic [Q_CNT_W-1:0] n_push;
  res_t               rd;

  assign any_push = push.va || push.vb;
  assign first    = push.va ? push.res_a : push.res_b;
  assign n_push   = Q_CNT_W'(push.va) + Q_CNT_W'(push.vb);
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign room2    = (count <= Q_CNT_W'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (any_push) begin
      mem[wptr] <= first;
    end
    if (push.va && push.vb) begin
      mem[wptr + 1'b1] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + Q_PTR_W'(n_push);
      rptr  <= rptr + Q_PTR_W'(pop);
      count <= count + n_push - Q_CNT_W'(pop);
    end
  end

  assign rd      = mem[rptr];
  assign m_tdata = {7'd0, rd.count, rd.failed, rd.data};
  assign m_tuser = rd.kind;
  assign m_tlast = rd.last;

  `HBT_ASSERT_ALWAYS(a_count_bound, count <= Q_CNT_W'(Q_DEPTH), "queue count beyond depth")
  `HBT_ASSERT_IMP(a_pair_room, push.va && push.vb, count <= Q_CNT_W'(Q_DEPTH - 2), "pair written without room")
  `HBT_ASSERT_NEXT(a_pop_drains, pop && !any_push, count == $past(count) - 1'b1, "read transfer did not drain queue")

endmodule

@@ rtl/hex_binary_text_to_bytes_top.sv @@
// top level of the text-to-bytes converter: limit register, converter, result queue
// depends on hbt_pkg, hbt_conv and hbt_outq
//
// characters arrive one per transfer on the s_ channel (tdata[7:0]); a zero
// character ends the string. results leave on the m_ channel: tuser is 0 for a
// data byte and 1 for the status that closes a string, which also has tlast set.
// status carries the failed flag and the byte count in tdata.
// output_limit is written through cfg_wr_en / cfg_wr_data while the block is idle,
// a rule for the user that the block does not enforce. a character in the input
// register is converted, and its results written into the result queue, once the
// queue has room for two entries. one character per cycle is sustained while each
// character gives at most one result and the receiver takes every result;
// characters that give two results fill the four-entry queue faster than its single
// read port drains it. reset sets the limit to 65535, clears the conversion state
// and empties the queue. when the receiver stalls, results wait in the queue and
// s_tready drops once fewer than two entries are free and a character is held.
module hex_binary_text_to_bytes_top import hbt_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,      // char_code
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,      // data_byte, failed, byte_count, zero fill
  output logic               m_tuser,      // kind
  output logic               m_tlast,      // is_last
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data   // output_limit
);

  logic [15:0] output_limit;
  logic        room2;
  push_t       push;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      output_limit <= cfg_wr_data;
    end
  end

  hbt_conv #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_conv (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .output_limit (output_limit),
    .room2        (room2),
    .push         (push)
  );

  hbt_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room2    (room2),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
